FILE: src/slid_pkg.sv
`default_nettype none

package slid_pkg;

  localparam int SlidCapacity = 16;
  localparam int ValueW       = 32;
  localparam int PosW         = 8;
  localparam int CountW       = 9;
  localparam int StatusW      = 2;

  typedef enum logic [StatusW-1:0] {
    StatDone  = 2'd0,
    StatFull  = 2'd1,
    StatRange = 2'd2,
    StatEmpty = 2'd3
  } status_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic rotate;  // ring shift toward cell 0
    logic insert;  // open a gap at the slot and drop the value in
    logic fill;    // overwrite the slot with the value
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: src/slid_cell.sv
`default_nettype none

module slid_cell
  import slid_pkg::*;
#(
  parameter int IdxW = 4,
  parameter int Idx  = 0
) (
  input  wire logic                    clk_i,
  input  wire cell_ctrl_t              ctrl_i,
  input  wire logic [IdxW-1:0]         slot_i,
  input  wire logic signed [ValueW-1:0] value_i,
  input  wire logic signed [ValueW-1:0] up_i,
  input  wire logic signed [ValueW-1:0] down_i,
  output logic signed [ValueW-1:0]     data_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(Idx);

  logic signed [ValueW-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.rotate) begin
      data_d = down_i;
    end else if (ctrl_i.insert) begin
      if (slot_i == MyIdx) begin
        data_d = value_i;
      end else if (slot_i < MyIdx) begin
        data_d = up_i;
      end
    end else if (ctrl_i.fill && slot_i == MyIdx) begin
      data_d = value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

FILE: src/slid_min.sv
`default_nettype none

module slid_min
  import slid_pkg::*;
#(
  parameter int IdxW = 4,
  parameter int CntW = 5
) (
  input  wire logic                     clk_i,
  input  wire logic                     step_i,
  input  wire logic [IdxW-1:0]          idx_i,
  input  wire logic signed [ValueW-1:0] head_i,
  input  wire logic [CntW-1:0]          count_i,
  output logic signed [ValueW-1:0]      best_o,
  output logic [IdxW-1:0]               slot_o,
  output logic signed [ValueW-1:0]      last_o
);

  logic signed [ValueW-1:0] best_q, best_d, last_q, last_d;
  logic [IdxW-1:0]          slot_q, slot_d;
  logic [CntW-1:0]          idx_ext;

  assign idx_ext = CntW'(idx_i);

  always_comb begin
    best_d = best_q;
    slot_d = slot_q;
    last_d = last_q;
    if (step_i && idx_ext < count_i) begin
      if (idx_i == '0 || head_i < best_q) begin
        best_d = head_i;
        slot_d = idx_i;
      end
      if (idx_ext + CntW'(1) == count_i) begin
        last_d = head_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    slot_q <= slot_d;
    last_q <= last_d;
  end

  assign best_o = best_q;
  assign slot_o = slot_q;
  assign last_o = last_q;

endmodule

`default_nettype wire

FILE: src/seq_list_insert_delete_min_unit.sv
// Bounded list of signed 32-bit words held in a row of cells.
// Request channel: action_i, position_i, value_i are taken at a rising
// edge with start_i high and busy_o low. Result channel: done_o is high
// for one cycle with status_o, removed_value_o and count_o; the receiver
// must take it then, it cannot stall the unit.
// Insert: checked and applied at the accepting edge; the result shows the
// next cycle and busy_o stays low, so an insert can follow every cycle.
// Delete-minimum: the cell ring rotates once fully in the scan state
// while a comparator at cell 0 tracks the first minimum and the last
// entry, then the fill state writes the last entry into the minimum's
// slot. The result is registered as the fill state ends; busy_o is high
// in the scan and fill states. A refused delete answers the next cycle.
// The ring length (Capacity) sets the delete time.
// Reset empties the list (count zero) and clears the strobe; cell contents
// are left as they are and never read before written.
`default_nettype none

module seq_list_insert_delete_min_unit
  import slid_pkg::*;
#(
  parameter int Capacity = SlidCapacity
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic                     action_i,
  input  wire logic [PosW-1:0]          position_i,
  input  wire logic signed [ValueW-1:0] value_i,
  output logic                          done_o,
  output logic [StatusW-1:0]            status_o,
  output logic signed [ValueW-1:0]      removed_value_o,
  output logic [CountW-1:0]             count_o
);

  localparam int IdxW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int CntW = $clog2(Capacity + 1);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StFill = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] idx_q, idx_d;

  logic                     done_q, done_d;
  status_e                  status_q, status_d;
  logic signed [ValueW-1:0] removed_q, removed_d;

  cell_ctrl_t               ctrl;
  logic [IdxW-1:0]          slot;
  logic signed [ValueW-1:0] cell_value;
  logic signed [ValueW-1:0] cell_data [Capacity];

  logic signed [ValueW-1:0] best;
  logic [IdxW-1:0]          best_slot;
  logic signed [ValueW-1:0] last;

  logic accept, is_full, out_range;
  logic [CountW-1:0] cnt_ext, pos_ext;

  assign accept  = start_i && state_q == StIdle;
  assign cnt_ext = CountW'(cnt_q);
  assign pos_ext = CountW'(position_i);
  assign is_full   = cnt_q == CntW'(Capacity);
  assign out_range = position_i == '0 || pos_ext > cnt_ext + CountW'(1);

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    slid_cell #(
      .IdxW (IdxW),
      .Idx  (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .slot_i  (slot),
      .value_i (cell_value),
      .up_i    (cell_data[(i + Capacity - 1) % Capacity]),
      .down_i  (cell_data[(i + 1) % Capacity]),
      .data_o  (cell_data[i])
    );
  end

  slid_min #(
    .IdxW (IdxW),
    .CntW (CntW)
  ) u_min (
    .clk_i   (clk_i),
    .step_i  (state_q == StScan),
    .idx_i   (idx_q),
    .head_i  (cell_data[0]),
    .count_i (cnt_q),
    .best_o  (best),
    .slot_o  (best_slot),
    .last_o  (last)
  );

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    done_d     = 1'b0;
    status_d   = status_q;
    removed_d  = removed_q;
    ctrl       = '0;
    slot       = best_slot;
    cell_value = last;

    case (state_q)
      StIdle: begin
        if (accept) begin
          done_d    = 1'b1;
          removed_d = '0;
          if (!action_i) begin
            if (is_full) begin
              status_d = StatFull;
            end else if (out_range) begin
              status_d = StatRange;
            end else begin
              status_d    = StatDone;
              ctrl.insert = 1'b1;
              slot        = IdxW'(position_i - PosW'(1));
              cell_value  = value_i;
              cnt_d       = cnt_q + CntW'(1);
            end
          end else if (cnt_q == '0) begin
            status_d = StatEmpty;
          end else begin
            done_d  = 1'b0;
            idx_d   = '0;
            state_d = StScan;
          end
        end
      end
      StScan: begin
        ctrl.rotate = 1'b1;
        idx_d       = idx_q + IdxW'(1);
        if (idx_q == IdxW'(Capacity - 1)) begin
          state_d = StFill;
        end
      end
      StFill: begin
        ctrl.fill = 1'b1;
        done_d    = 1'b1;
        status_d  = StatDone;
        removed_d = best;
        cnt_d     = cnt_q - CntW'(1);
        state_d   = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    status_q  <= status_d;
    removed_q <= removed_d;
  end

  assign busy_o          = state_q != StIdle;
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign count_o         = CountW'(cnt_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Capacity))
    else $error("list count above capacity");

  a_delete_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && action_i && cnt_q != '0 |=> state_q == StScan && !done_o)
    else $error("delete request did not start a scan");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != StatDone |-> removed_value_o == '0)
    else $error("refused request returned a value");

  a_fill_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFill |=> done_o && cnt_q == $past(cnt_q) - CntW'(1))
    else $error("delete did not shrink the list");

endmodule

`default_nettype wire

FILE: tb/seq_list_checker.sv
`timescale 1ns / 100ps

package slid_tb_pkg;

  localparam logic ActInsert    = 1'b0;
  localparam logic ActDeleteMin = 1'b1;

endpackage

module seq_list_checker
  import slid_pkg::*;
  import slid_tb_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     busy_i,
  input  logic                     action_i,
  input  logic [PosW-1:0]          position_i,
  input  logic signed [ValueW-1:0] value_i,
  input  logic                     done_i,
  input  logic [StatusW-1:0]       status_i,
  input  logic signed [ValueW-1:0] removed_value_i,
  input  logic [CountW-1:0]        count_i,
  output int                       mismatch_count_o,
  output int                       outstanding_o,
  output int                       list_count_o
);

  typedef struct {
    status_e                  status;
    logic signed [ValueW-1:0] removed;
    logic [CountW-1:0]        count;
  } list_result_t;

  list_result_t             answers_q[$];
  logic signed [ValueW-1:0] list_mem [SlidCapacity];
  int                       list_len;

  function automatic list_result_t apply_request(logic act, logic [PosW-1:0] pos,
                                                 logic signed [ValueW-1:0] val);
    list_result_t             res;
    int                       p;
    int                       slot;
    logic signed [ValueW-1:0] best;
    p = int'(pos);
    res.status  = StatDone;
    res.removed = '0;
    if (act == ActInsert) begin
      if (list_len >= SlidCapacity) begin
        res.status = StatFull;
      end else if (p < 1 || p > list_len + 1) begin
        res.status = StatRange;
      end else begin
        for (int i = list_len; i >= p; i--) list_mem[i] = list_mem[i-1];
        list_mem[p-1] = val;
        list_len++;
      end
    end else begin
      if (list_len == 0) begin
        res.status = StatEmpty;
      end else begin
        best = list_mem[0];
        slot = 0;
        for (int i = 1; i < list_len; i++) begin
          if (list_mem[i] < best) begin
            best = list_mem[i];
            slot = i;
          end
        end
        list_mem[slot] = list_mem[list_len-1];
        list_len--;
        res.removed = best;
      end
    end
    res.count = CountW'(list_len);
    return res;
  endfunction

  function automatic void flag_mismatch(string what);
    if (mismatch_count_o < 10) $display("%0t: %s", $time, what);
    mismatch_count_o++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    if (!rst_ni) begin
      answers_q.delete();
      list_len         = 0;
      mismatch_count_o = 0;
    end else begin
      if (done_i) begin
        if (answers_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result: status %0d removed %0d count %0d",
                                  status_i, removed_value_i, count_i));
        end else begin
          want = answers_q.pop_front();
          if (status_i !== want.status || removed_value_i !== want.removed ||
              count_i !== want.count) begin
            flag_mismatch($sformatf(
              "expected status %0d removed %0d count %0d, got status %0d removed %0d count %0d",
              want.status, want.removed, want.count, status_i, removed_value_i, count_i));
          end
        end
      end
      if (start_i && !busy_i) answers_q.push_back(apply_request(action_i, position_i, value_i));
    end
    outstanding_o = answers_q.size();
    list_count_o  = list_len;
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import slid_pkg::*;
  import slid_tb_pkg::*;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  logic                     busy_o;
  logic                     action_i = ActInsert;
  logic [PosW-1:0]          position_i = '0;
  logic signed [ValueW-1:0] value_i = '0;
  logic                     done_o;
  logic [StatusW-1:0]       status_o;
  logic signed [ValueW-1:0] removed_value_o;
  logic [CountW-1:0]        count_o;

  int mismatch_count;
  int outstanding;
  int list_count;
  bit gaps_on = 1'b1;
  bit growing = 1'b1;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  seq_list_insert_delete_min_unit dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .action_i,
    .position_i,
    .value_i,
    .done_o,
    .status_o,
    .removed_value_o,
    .count_o
  );

  seq_list_checker checker_i (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_i          (busy_o),
    .action_i,
    .position_i,
    .value_i,
    .done_i          (done_o),
    .status_i        (status_o),
    .removed_value_i (removed_value_o),
    .count_i         (count_o),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding),
    .list_count_o    (list_count)
  );

  task automatic send_request(logic act, logic [PosW-1:0] pos, logic signed [ValueW-1:0] val);
    int gap;
    gap = gaps_on ? $urandom_range(0, 6) : 0;
    repeat (gap) begin
      start_i    = 1'b0;
      action_i   = 1'($urandom);
      position_i = PosW'($urandom);
      value_i    = $urandom;
      @(negedge clk_i);
    end
    start_i    = 1'b1;
    action_i   = act;
    position_i = pos;
    value_i    = val;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  task automatic drain;
    start_i = 1'b0;
    wait (outstanding == 0);
    @(negedge clk_i);
  endtask

  function automatic logic signed [ValueW-1:0] pick_value();
    case ($urandom_range(0, 4))
      0:       return ValueW'($urandom_range(0, 8)) - 4;
      1: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh7fffffff;
          1:       return 32'sh80000000;
          2:       return '0;
          default: return -1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [PosW-1:0] pick_position(int held);
    if ($urandom_range(0, 99) < 85) return PosW'($urandom_range(1, held + 1));
    if ($urandom_range(0, 2) == 0) return '0;
    return PosW'($urandom_range(held + 2, 255));
  endfunction

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: refusals, extremes, append, middle insert, full list, ties
    send_request(ActDeleteMin, 8'd0, '0);
    send_request(ActInsert, 8'd0, 32'sd11);
    send_request(ActInsert, 8'd2, 32'sd12);
    send_request(ActInsert, 8'd1, 32'sh7fffffff);
    send_request(ActInsert, 8'd2, 32'sh80000000);
    send_request(ActInsert, 8'd1, -32'sd1);
    send_request(ActInsert, PosW'(list_count + 1), 32'sd0);
    send_request(ActInsert, 8'd255, 32'sh55aa55aa);
    send_request(ActInsert, 8'd2, 32'sd0);
    send_request(ActDeleteMin, 8'hff, 32'shffffffff);
    while (list_count < SlidCapacity) begin
      send_request(ActInsert, PosW'($urandom_range(1, list_count + 1)), -32'sd7);
    end
    send_request(ActInsert, PosW'($urandom_range(1, 17)), 32'sd3);
    send_request(ActDeleteMin, 8'd0, '0);
    send_request(ActDeleteMin, 8'd0, '0);
    drain();

    for (int n = 0; n < 1800; n++) begin
      if (n % 60 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 19) == 0) growing = !growing;
      if (n == 900 || $urandom_range(0, 99) == 0) drain();
      if ($urandom_range(0, 99) < (growing ? 20 : 75)) begin
        send_request(ActDeleteMin, PosW'($urandom), $urandom);
      end else begin
        send_request(ActInsert, pick_position(list_count), pick_value());
      end
    end
    start_i = 1'b0;

    wait (outstanding == 0);
    repeat (SlidCapacity + 4) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("seq_list_insert_delete_min_unit test passed");
    end else begin
      $display("seq_list_insert_delete_min_unit test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("seq_list_insert_delete_min_unit test failed");
    $finish;
  end

endmodule
